// ===== rtl/stft_power_spectrum_db_assert.svh =====
// Assertion macros for the spectrum block.
`ifndef STFT_POWER_SPECTRUM_DB_ASSERT_SVH
`define STFT_POWER_SPECTRUM_DB_ASSERT_SVH
`ifndef SYNTHESIS
`define SPDB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spdb assertion failed");
`define SPDB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spdb assertion failed");
`else
`define SPDB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SPDB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/spdb_pkg.sv =====
package spdb_pkg;

    localparam int FFT_LEN   = 64;
    localparam int LOG_N     = $clog2(FFT_LEN);
    localparam int HALF_BINS = FFT_LEN / 2;
    localparam int STRIDE    = FFT_LEN / 4;
    localparam int STRIDE_W  = $clog2(STRIDE);

    localparam int SAMPLE_W = 16;
    localparam int WIN_W    = 17;
    localparam int WS_W     = SAMPLE_W + WIN_W;
    localparam int TW_W     = 26;
    localparam int PROD_W   = WS_W + TW_W;
    localparam int ACC_W    = 64;
    localparam int MAG_W    = 31;
    localparam int POW_W    = 2 * MAG_W;
    localparam int LEVEL_W  = 17;
    localparam int BIN_W    = 7;
    localparam int FRAME_W  = 32;
    localparam int FRAC_W   = 24;
    localparam int SQR_STEPS = 24;
    localparam int NORM_STEPS = 6;
    localparam int LPROD_W  = 59;

    localparam logic signed [LEVEL_W-1:0] ZERO_LEVEL = -17'sd40073;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN  = -17'sd40960;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX  = 17'sd12288;
    localparam logic signed [26:0]        KDB_Q16    = 27'sd50504453;
    localparam logic signed [31:0]        L_OFFSET   = 32'sd805306368;

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint HALFPI_Q30 = 64'sd1686629713;
    localparam longint WIN_D      = FFT_LEN - 1;
    localparam longint WIN_DEN    = 64'sd327680000000;
    localparam int     PH_SHIFT   = 32 - LOG_N;

    typedef logic [WIN_W-1:0]        win_tab_t [FFT_LEN];
    typedef logic signed [TW_W-1:0]  cos_tab_t [FFT_LEN];

    typedef struct packed {
        logic                       done;
        logic signed [LEVEL_W-1:0]  level;
    } log_res_t;

    function automatic longint unsigned horner_div(input int n, input longint unsigned p);
        case (n)
            0: return p / 182;
            1: return p / 132;
            2: return p / 90;
            3: return p / 56;
            4: return p / 30;
            5: return p / 12;
            default: return p / 2;
        endcase
    endfunction

    function automatic longint cos_q30(input logic [31:0] phase);
        logic [1:0] quad;
        longint unsigned frac;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint t;
        int n;
        quad = phase[31:30];
        frac = {34'd0, phase[29:0]};
        if (quad[0]) begin
            frac = 64'h40000000 - frac;
        end
        x  = (frac * 64'(HALFPI_Q30) + (64'd1 << 29)) >> 30;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = Q30_ONE;
        for (n = 0; n < 7; n++) begin
            p = (x2 * 64'(t)) >> 30;
            t = Q30_ONE - $signed(horner_div(n, p));
            if (t < 0) begin
                t = 0;
            end
        end
        return (quad == 2'd1 || quad == 2'd2) ? -t : t;
    endfunction

    function automatic logic [31:0] win_phase(input longint a);
        longint r;
        r = a % WIN_D;
        return 32'(((r << 32) + WIN_D / 2) / WIN_D);
    endfunction

    function automatic longint round6(input longint v);
        if (v < 0) begin
            return -((-v + 32) >>> 6);
        end
        return (v + 32) >>> 6;
    endfunction

    function automatic win_tab_t build_win();
        win_tab_t tab;
        longint j;
        longint num;
        int i;
        for (i = 0; i < FFT_LEN; i++) begin
            j = (i < WIN_D - i) ? i : WIN_D - i;
            num = 64'sd3635819 * Q30_ONE
                - 64'sd4891775 * cos_q30(win_phase(j))
                + 64'sd1365995 * cos_q30(win_phase(2 * j))
                - 64'sd106411 * cos_q30(win_phase(3 * j));
            if (num < 0) begin
                tab[i] = '0;
            end else begin
                tab[i] = WIN_W'((num + WIN_DEN / 2) / WIN_DEN);
            end
        end
        return tab;
    endfunction

    function automatic cos_tab_t build_cos();
        cos_tab_t tab;
        int m;
        for (m = 0; m < FFT_LEN; m++) begin
            tab[m] = TW_W'(round6(cos_q30(32'(m) << PH_SHIFT)));
        end
        return tab;
    endfunction

    localparam win_tab_t WIN_TABLE = build_win();
    localparam cos_tab_t COS_TABLE = build_cos();

endpackage

// ===== rtl/spdb_ram.sv =====
module spdb_ram #(
    parameter int WIDTH = spdb_pkg::WS_W,
    parameter int DEPTH = spdb_pkg::FFT_LEN
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/spdb_log.sv =====
module spdb_log (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [spdb_pkg::POW_W-1:0]    power,
    output spdb_pkg::log_res_t            res
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_NORM = 3'd1;
    localparam logic [2:0] L_SQR  = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_RND  = 3'd4;

    localparam int LW = spdb_pkg::LEVEL_W;
    localparam int PW = spdb_pkg::LPROD_W;

    logic [2:0]  st_reg, st_next;
    logic [4:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] p_reg, p_next;
    logic [5:0]  e_reg, e_next;
    logic [30:0] m_reg, m_next;
    logic [spdb_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [LW-1:0] level_reg, level_next;

    logic        top_zero;
    logic [5:0]  amt;
    logic [63:0] p_shift;
    logic [61:0] sq;
    logic [31:0] sq_hi;
    logic signed [31:0] lval;
    logic signed [PW-1:0] lval_x;
    logic signed [PW-1:0] kdb_x;
    logic [PW-1:0] rnd_mag;
    logic signed [19:0] lv;

    always_comb begin
        case (step_reg)
            5'd0: begin top_zero = (p_reg[63:32] == '0); amt = 6'd32; end
            5'd1: begin top_zero = (p_reg[63:48] == '0); amt = 6'd16; end
            5'd2: begin top_zero = (p_reg[63:56] == '0); amt = 6'd8;  end
            5'd3: begin top_zero = (p_reg[63:60] == '0); amt = 6'd4;  end
            5'd4: begin top_zero = (p_reg[63:62] == '0); amt = 6'd2;  end
            5'd5: begin top_zero = !p_reg[63];            amt = 6'd1;  end
            default: begin top_zero = 1'b0; amt = 6'd0; end
        endcase
    end

    assign p_shift = top_zero ? (p_reg << amt) : p_reg;
    assign sq      = 62'(m_reg) * 62'(m_reg);
    assign sq_hi   = sq[61:30];
    assign lval    = $signed({2'b00, e_reg, frac_reg}) - spdb_pkg::L_OFFSET;
    assign lval_x  = PW'(lval);
    assign kdb_x   = PW'(spdb_pkg::KDB_Q16);
    assign rnd_mag = prod_reg[PW-1]
                   ? ((PW'(-prod_reg) + (PW'(1) << 39)) >> 40)
                   : ((PW'(prod_reg) + (PW'(1) << 39)) >> 40);
    assign lv      = prod_reg[PW-1] ? -$signed(20'(rnd_mag)) : $signed(20'(rnd_mag));

    always_comb begin
        st_next    = st_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        p_next     = p_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        prod_next  = prod_reg;
        level_next = level_reg;
        case (st_reg)
            L_IDLE: begin
                if (start) begin
                    if (power == '0) begin
                        level_next = spdb_pkg::ZERO_LEVEL;
                        done_next  = 1'b1;
                    end else begin
                        p_next    = 64'(power);
                        e_next    = 6'd63;
                        step_next = '0;
                        st_next   = L_NORM;
                    end
                end
            end
            L_NORM: begin
                p_next = p_shift;
                if (top_zero) begin
                    e_next = e_reg - amt;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(spdb_pkg::NORM_STEPS - 1)) begin
                    m_next    = p_shift[63:33];
                    frac_next = '0;
                    step_next = '0;
                    st_next   = L_SQR;
                end
            end
            L_SQR: begin
                if (sq_hi[31]) begin
                    m_next    = sq_hi[31:1];
                    frac_next = {frac_reg[spdb_pkg::FRAC_W-2:0], 1'b1};
                end else begin
                    m_next    = sq_hi[30:0];
                    frac_next = {frac_reg[spdb_pkg::FRAC_W-2:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(spdb_pkg::SQR_STEPS - 1)) begin
                    st_next = L_MUL;
                end
            end
            L_MUL: begin
                prod_next = lval_x * kdb_x;
                st_next   = L_RND;
            end
            L_RND: begin
                if (lv < 20'(spdb_pkg::LEVEL_MIN)) begin
                    level_next = spdb_pkg::LEVEL_MIN;
                end else if (lv > 20'(spdb_pkg::LEVEL_MAX)) begin
                    level_next = spdb_pkg::LEVEL_MAX;
                end else begin
                    level_next = LW'(lv);
                end
                done_next = 1'b1;
                st_next   = L_IDLE;
            end
            default: begin
                st_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= L_IDLE;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg     <= p_next;
        e_reg     <= e_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        prod_reg  <= prod_next;
        level_reg <= level_next;
    end

    assign res.done  = done_reg;
    assign res.level = level_reg;

endmodule

// ===== rtl/stft_power_spectrum_db.sv =====
// Channel   Dir  Handshake           Word
// s_        in   s_valid / s_ready   s_sample (Q1.15)
// m_        out  m_valid / m_ready   m_level_db, m_bin_number, m_frame_number, m_last_bin
//
// A sample that completes no frame leaves s_ready high.
// A completing sample holds s_ready low for the frame: windowing, then per bin
// DFT accumulation, power, the log unit (normalize, then squaring; both skipped
// on zero power) and loading of the output word.
// Output stalls lengthen the frame; s_ready stays low until the last bin is registered.
// Reset clears control state only; history fills before any frame.
module stft_power_spectrum_db (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [spdb_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [spdb_pkg::LEVEL_W-1:0]  m_level_db,
    output logic [spdb_pkg::BIN_W-1:0]           m_bin_number,
    output logic [spdb_pkg::FRAME_W-1:0]         m_frame_number,
    output logic                                 m_last_bin
);

`include "stft_power_spectrum_db_assert.svh"

    localparam int N    = spdb_pkg::FFT_LEN;
    localparam int LN   = spdb_pkg::LOG_N;
    localparam int ACCW = spdb_pkg::ACC_W;
    localparam int MW   = spdb_pkg::MAG_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WIN  = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_POW  = 3'd3;
    localparam logic [2:0] ST_LOG  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [LN-1:0] LAST_IDX = LN'(N - 1);
    localparam logic [LN-1:0] LAST_K   = LN'(spdb_pkg::HALF_BINS);
    localparam logic [LN-1:0] QUARTER  = LN'(N / 4);
    localparam logic [LN:0]   CNT_END  = (LN + 1)'(N);

    logic [2:0]    state_reg, state_next;
    logic [LN-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LN:0]   fill_reg, fill_next;
    logic [spdb_pkg::STRIDE_W-1:0] phase_reg, phase_next;
    logic [spdb_pkg::FRAME_W-1:0]  frame_cnt_reg, frame_cnt_next;
    logic [LN:0]   cnt_reg, cnt_next;
    logic [LN-1:0] k_reg, k_next;
    logic [LN-1:0] ph_reg, ph_next;
    logic          win_v_reg, win_v_next;
    logic [LN-1:0] win_idx_reg, win_idx_next;
    logic          rd_v_reg, rd_v_next;
    logic          rd_last_reg, rd_last_next;
    logic [LN-1:0] rd_ph_reg, rd_ph_next;
    logic          pr_v_reg, pr_v_next;
    logic          pr_last_reg, pr_last_next;
    logic [1:0]    pow_step_reg, pow_step_next;
    logic          log_start_reg, log_start_next;
    logic          m_valid_reg, m_valid_next;

    logic signed [spdb_pkg::PROD_W-1:0] prod_re_reg, prod_re_next;
    logic signed [spdb_pkg::PROD_W-1:0] prod_im_reg, prod_im_next;
    logic signed [ACCW-1:0] acc_re_reg, acc_re_next;
    logic signed [ACCW-1:0] acc_im_reg, acc_im_next;
    logic [MW-1:0] ar_reg, ar_next;
    logic [MW-1:0] ai_reg, ai_next;
    logic [spdb_pkg::POW_W-1:0] sq_re_reg, sq_re_next;
    logic [spdb_pkg::POW_W-1:0] sq_im_reg, sq_im_next;
    logic [spdb_pkg::POW_W-1:0] power_reg, power_next;
    logic signed [spdb_pkg::LEVEL_W-1:0] m_level_reg, m_level_next;
    logic [spdb_pkg::BIN_W-1:0]   m_bin_reg, m_bin_next;
    logic [spdb_pkg::FRAME_W-1:0] m_frame_reg, m_frame_next;
    logic          m_last_reg, m_last_next;

    logic          accept;
    logic          out_load;
    logic [LN-1:0] hist_raddr;
    logic [spdb_pkg::SAMPLE_W-1:0] hist_rdata;
    logic signed [spdb_pkg::WS_W-1:0] win_prod;
    logic [spdb_pkg::WS_W-1:0] ws_rdata;
    logic [ACCW-1:0] re_abs;
    logic [ACCW-1:0] im_abs;
    logic [ACCW-1:0] re_mag;
    logic [ACCW-1:0] im_mag;
    spdb_pkg::log_res_t log_res;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign hist_raddr = wr_ptr_reg + cnt_reg[LN-1:0];
    assign win_prod   = spdb_pkg::WS_W'($signed(hist_rdata))
                      * spdb_pkg::WS_W'($signed({1'b0, spdb_pkg::WIN_TABLE[win_idx_reg]}));
    assign out_load   = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign re_abs = acc_re_reg[ACCW-1] ? ACCW'(-acc_re_reg) : ACCW'(acc_re_reg);
    assign im_abs = acc_im_reg[ACCW-1] ? ACCW'(-acc_im_reg) : ACCW'(acc_im_reg);
    assign re_mag = (re_abs + (ACCW'(1) << 29)) >> 30;
    assign im_mag = (im_abs + (ACCW'(1) << 29)) >> 30;

    spdb_ram #(
        .WIDTH(spdb_pkg::SAMPLE_W),
        .DEPTH(N)
    ) u_hist (
        .aclk (aclk),
        .we   (accept),
        .waddr(wr_ptr_reg),
        .wdata(s_sample),
        .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    spdb_ram #(
        .WIDTH(spdb_pkg::WS_W),
        .DEPTH(N)
    ) u_work (
        .aclk (aclk),
        .we   (win_v_reg),
        .waddr(win_idx_reg),
        .wdata(win_prod),
        .raddr(cnt_reg[LN-1:0]),
        .rdata(ws_rdata)
    );

    spdb_log u_log (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (log_start_reg),
        .power  (power_reg),
        .res    (log_res)
    );

    always_comb begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        frame_cnt_next = frame_cnt_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        ph_next        = ph_reg;
        win_v_next     = 1'b0;
        win_idx_next   = win_idx_reg;
        rd_v_next      = 1'b0;
        rd_last_next   = 1'b0;
        rd_ph_next     = rd_ph_reg;
        pr_v_next      = rd_v_reg;
        pr_last_next   = rd_last_reg;
        pow_step_next  = pow_step_reg;
        log_start_next = 1'b0;
        prod_re_next   = spdb_pkg::PROD_W'($signed(ws_rdata))
                       * spdb_pkg::PROD_W'(spdb_pkg::COS_TABLE[rd_ph_reg]);
        prod_im_next   = spdb_pkg::PROD_W'($signed(ws_rdata))
                       * spdb_pkg::PROD_W'(spdb_pkg::COS_TABLE[rd_ph_reg - QUARTER]);
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        ar_next        = ar_reg;
        ai_next        = ai_reg;
        sq_re_next     = sq_re_reg;
        sq_im_next     = sq_im_reg;
        power_next     = power_reg;
        m_level_next   = m_level_reg;
        m_bin_next     = m_bin_reg;
        m_frame_next   = m_frame_reg;
        m_last_next    = m_last_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                    if (fill_reg != CNT_END) begin
                        fill_next = fill_reg + 1'b1;
                        if (fill_reg == CNT_END - 1'b1) begin
                            phase_next = '0;
                            cnt_next   = '0;
                            state_next = ST_WIN;
                        end
                    end else begin
                        phase_next = phase_reg + 1'b1;
                        if (phase_reg == spdb_pkg::STRIDE_W'(spdb_pkg::STRIDE - 1)) begin
                            phase_next = '0;
                            cnt_next   = '0;
                            state_next = ST_WIN;
                        end
                    end
                end
            end
            ST_WIN: begin
                if (cnt_reg != CNT_END) begin
                    cnt_next     = cnt_reg + 1'b1;
                    win_v_next   = 1'b1;
                    win_idx_next = cnt_reg[LN-1:0];
                end
                if (win_v_reg && win_idx_reg == LAST_IDX) begin
                    cnt_next    = '0;
                    k_next      = LN'(1);
                    ph_next     = '0;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC: begin
                if (cnt_reg != CNT_END) begin
                    cnt_next     = cnt_reg + 1'b1;
                    rd_v_next    = 1'b1;
                    rd_last_next = (cnt_reg[LN-1:0] == LAST_IDX);
                    rd_ph_next   = ph_reg;
                    ph_next      = ph_reg + k_reg;
                end
                if (pr_v_reg) begin
                    acc_re_next = acc_re_reg + ACCW'(prod_re_reg);
                    acc_im_next = acc_im_reg - ACCW'(prod_im_reg);
                    if (pr_last_reg) begin
                        pow_step_next = '0;
                        state_next    = ST_POW;
                    end
                end
            end
            ST_POW: begin
                pow_step_next = pow_step_reg + 1'b1;
                case (pow_step_reg)
                    2'd0: begin
                        ar_next = re_mag[MW-1:0];
                        ai_next = (k_reg == LAST_K) ? '0 : im_mag[MW-1:0];
                    end
                    2'd1: begin
                        sq_re_next = spdb_pkg::POW_W'(ar_reg) * spdb_pkg::POW_W'(ar_reg);
                        sq_im_next = spdb_pkg::POW_W'(ai_reg) * spdb_pkg::POW_W'(ai_reg);
                    end
                    default: begin
                        power_next     = sq_re_reg + sq_im_reg;
                        log_start_next = 1'b1;
                        state_next     = ST_LOG;
                    end
                endcase
            end
            ST_LOG: begin
                if (log_res.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_level_next = log_res.level;
                    m_bin_next   = spdb_pkg::BIN_W'(k_reg);
                    m_frame_next = frame_cnt_reg;
                    m_last_next  = (k_reg == LAST_K);
                    if (k_reg == LAST_K) begin
                        frame_cnt_next = frame_cnt_reg + 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        k_next      = k_reg + 1'b1;
                        cnt_next    = '0;
                        ph_next     = '0;
                        acc_re_next = '0;
                        acc_im_next = '0;
                        state_next  = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            frame_cnt_reg <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            ph_reg        <= '0;
            win_v_reg     <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            pr_v_reg      <= 1'b0;
            pr_last_reg   <= 1'b0;
            pow_step_reg  <= '0;
            log_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            frame_cnt_reg <= frame_cnt_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            ph_reg        <= ph_next;
            win_v_reg     <= win_v_next;
            rd_v_reg      <= rd_v_next;
            rd_last_reg   <= rd_last_next;
            pr_v_reg      <= pr_v_next;
            pr_last_reg   <= pr_last_next;
            pow_step_reg  <= pow_step_next;
            log_start_reg <= log_start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_idx_reg <= win_idx_next;
        rd_ph_reg   <= rd_ph_next;
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
        ar_reg      <= ar_next;
        ai_reg      <= ai_next;
        sq_re_reg   <= sq_re_next;
        sq_im_reg   <= sq_im_next;
        power_reg   <= power_next;
        m_level_reg <= m_level_next;
        m_bin_reg   <= m_bin_next;
        m_frame_reg <= m_frame_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_level_db     = m_level_reg;
    assign m_bin_number   = m_bin_reg;
    assign m_frame_number = m_frame_reg;
    assign m_last_bin     = m_last_reg;

    `SPDB_ASSERT_IMP(a_last_bin_k, aclk, aresetn, m_valid && m_last_bin, m_bin_number == spdb_pkg::BIN_W'(spdb_pkg::HALF_BINS))
    `SPDB_ASSERT_IMP(a_bin_range, aclk, aresetn, m_valid, (m_bin_number != '0) && (m_bin_number <= spdb_pkg::BIN_W'(spdb_pkg::HALF_BINS)))
    `SPDB_ASSERT_IMP(a_log_done_state, aclk, aresetn, log_res.done, state_reg == ST_LOG)
    `SPDB_ASSERT_NXT(a_frame_step, aclk, aresetn, out_load && (k_reg == LAST_K), frame_cnt_reg == $past(frame_cnt_reg) + 32'd1)

endmodule
